>>> hw/rtl/crlm_pkg.sv
// ----------------------------------------------------------------------------
// crlm_pkg
// Shared types and constants of the circular region log manager.
// ----------------------------------------------------------------------------
`default_nettype none

package crlm_pkg;

  // Operation codes carried in tuser
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_LOCATE = 2'd1;
  localparam logic [1:0] OP_FREE   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_END      = 2'd3;

  // Register addresses (byte addresses on the APB port)
  localparam logic [2:0] REG_BASE_ADDRESS = 3'd0;
  localparam logic [2:0] REG_REGION_SIZE  = 3'd4;

  localparam logic [23:0] REGION_HDR       = 24'd8;
  localparam logic [16:0] RECORD_HDR       = 17'd3;
  localparam logic [23:0] REGION_SIZE_RST  = 24'd4096;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_MUL,
    S_EMIT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_READ,
    CMD_APP_OK,
    CMD_APP_GROW,
    CMD_APP_FAIL,
    CMD_LOC_HIT,
    CMD_LOC_NEXT,
    CMD_LOC_END,
    CMD_FREE_NEXT,
    CMD_FREE_DONE,
    CMD_CLR_WRITE,
    CMD_MUL,
    CMD_EMIT
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       fits;
    logic       can_grow;
    logic       loc_hit;
    logic       loc_last;
    logic       free_last;
    logic       clr_last;
    logic       out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/circular_region_log_manager_unit.sv
// ----------------------------------------------------------------------------
// circular_region_log_manager_unit
// Ring allocator of equal flash log regions: append, locate, free, clear.
// ----------------------------------------------------------------------------
// Each transaction steps through the read, evaluate, multiply and emit states;
// append reads a second region when a new one is taken, locate and free
// space walk the ring one region per read/evaluate pair, and clear emits
// one result per region cleared. A stalled result holds the walk.
// Reset (synchronous, rst_n low) restores ring state and fill valid bits
// at once; no clearing pass.
`default_nettype none

module circular_region_log_manager_unit #(
  parameter int REGION_COUNT = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  // fields from bit 0: length[15:0], data_sum[23:16], log_offset[50:24],
  // clear_count[57:51], zero pad
  input  wire  [63:0]  in_tdata,
  // operation[1:0]
  input  wire  [1:0]   in_tuser,
  input  wire          in_tvalid,
  output logic         in_tready,
  // fields from bit 0: status[1:0], flash_address[33:2], amount[64:34],
  // header_checksum[72:65], region_index[78:73], region_offset[102:79],
  // sequence_number[134:103], zero pad
  output logic [135:0] out_tdata,
  output logic         out_tlast,
  output logic         out_tvalid,
  input  wire          out_tready,
  input  wire          cfg_psel,
  input  wire          cfg_penable,
  input  wire          cfg_pwrite,
  input  wire  [2:0]   cfg_paddr,
  input  wire  [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [31:0] base_address_r;
  logic [23:0] region_size_r;

  // configuration registers
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_address_r <= '0;
      region_size_r  <= crlm_pkg::REGION_SIZE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2]) begin
        region_size_r <= cfg_pwdata[23:0];
      end else begin
        base_address_r <= cfg_pwdata;
      end
    end
  end

  always_comb begin
    case (cfg_paddr)
      crlm_pkg::REG_BASE_ADDRESS: cfg_prdata = base_address_r;
      crlm_pkg::REG_REGION_SIZE:  cfg_prdata = {8'd0, region_size_r};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  crlm_pkg::dp_cmd_t    cmd;
  crlm_pkg::dp_status_t st;

  logic [1:0]  o_status;
  logic [31:0] o_addr;
  logic [30:0] o_amount;
  logic [7:0]  o_csum;
  logic [5:0]  o_ridx;
  logic [23:0] o_roff;
  logic [31:0] o_seq;

  crlm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  crlm_dp #(
    .REGION_COUNT (REGION_COUNT)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .base_address        (base_address_r),
    .region_size         (region_size_r),
    .in_operation        (in_tuser),
    .in_length           (in_tdata[15:0]),
    .in_data_sum         (in_tdata[23:16]),
    .in_log_offset       (in_tdata[50:24]),
    .in_clear_count      (in_tdata[57:51]),
    .out_valid           (out_tvalid),
    .out_ready           (out_tready),
    .out_status          (o_status),
    .out_flash_address   (o_addr),
    .out_amount          (o_amount),
    .out_header_checksum (o_csum),
    .out_region_index    (o_ridx),
    .out_region_offset   (o_roff),
    .out_sequence_number (o_seq),
    .out_last            (out_tlast)
  );

  assign out_tdata = {1'b0, o_seq, o_roff, o_ridx, o_csum, o_amount, o_addr, o_status};

endmodule

`default_nettype wire

>>> hw/rtl/crlm_ram.sv
// ----------------------------------------------------------------------------
// crlm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module crlm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  wire                                   clk,
  input  wire                                   we,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                      wdata,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/crlm_ctrl.sv
// ----------------------------------------------------------------------------
// crlm_ctrl
// Sequencer: walks the region ring one region per read/evaluate pair.
// ----------------------------------------------------------------------------
`default_nettype none

module crlm_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  crlm_pkg::dp_status_t  st,
  output crlm_pkg::dp_cmd_t     cmd
);

  crlm_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crlm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = crlm_pkg::CMD_NONE;
    in_ready  = 1'b0;
    case (state_r)
      crlm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd       = crlm_pkg::CMD_LOAD;
          state_nxt = crlm_pkg::S_READ;
        end
      end
      crlm_pkg::S_READ: begin
        cmd       = crlm_pkg::CMD_READ;
        state_nxt = crlm_pkg::S_EVAL;
      end
      crlm_pkg::S_EVAL: begin
        state_nxt = crlm_pkg::S_MUL;
        case (st.op)
          crlm_pkg::OP_APPEND: begin
            if (st.fits) begin
              cmd = crlm_pkg::CMD_APP_OK;
            end else if (st.can_grow) begin
              cmd       = crlm_pkg::CMD_APP_GROW;
              state_nxt = crlm_pkg::S_READ;
            end else begin
              cmd = crlm_pkg::CMD_APP_FAIL;
            end
          end
          crlm_pkg::OP_LOCATE: begin
            if (st.loc_hit) begin
              cmd = crlm_pkg::CMD_LOC_HIT;
            end else if (st.loc_last) begin
              cmd = crlm_pkg::CMD_LOC_END;
            end else begin
              cmd       = crlm_pkg::CMD_LOC_NEXT;
              state_nxt = crlm_pkg::S_READ;
            end
          end
          crlm_pkg::OP_FREE: begin
            if (st.free_last) begin
              cmd = crlm_pkg::CMD_FREE_DONE;
            end else begin
              cmd       = crlm_pkg::CMD_FREE_NEXT;
              state_nxt = crlm_pkg::S_READ;
            end
          end
          default: begin
            cmd = crlm_pkg::CMD_CLR_WRITE;
          end
        endcase
      end
      crlm_pkg::S_MUL: begin
        cmd       = crlm_pkg::CMD_MUL;
        state_nxt = crlm_pkg::S_EMIT;
      end
      crlm_pkg::S_EMIT: begin
        // hold until the output register can take the result
        if (!st.out_busy) begin
          cmd = crlm_pkg::CMD_EMIT;
          if (st.op == crlm_pkg::OP_CLEAR && !st.clr_last) begin
            state_nxt = crlm_pkg::S_READ;
          end else begin
            state_nxt = crlm_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = crlm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/crlm_dp.sv
// ----------------------------------------------------------------------------
// crlm_dp
// Datapath: ring state, fill RAM with valid bits, walk registers, result.
// ----------------------------------------------------------------------------
`default_nettype none

module crlm_dp #(
  parameter int REGION_COUNT = 8
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  crlm_pkg::dp_cmd_t    cmd,
  output crlm_pkg::dp_status_t st,
  input  wire  [31:0]          base_address,
  input  wire  [23:0]          region_size,
  input  wire  [1:0]           in_operation,
  input  wire  [15:0]          in_length,
  input  wire  [7:0]           in_data_sum,
  input  wire  [26:0]          in_log_offset,
  input  wire  [6:0]           in_clear_count,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [1:0]           out_status,
  output logic [31:0]          out_flash_address,
  output logic [30:0]          out_amount,
  output logic [7:0]           out_header_checksum,
  output logic [5:0]           out_region_index,
  output logic [23:0]          out_region_offset,
  output logic [31:0]          out_sequence_number,
  output logic                 out_last
);

  localparam int IW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam int CW = $clog2(REGION_COUNT + 1);
  localparam int SW = CW + 1;
  localparam int PW = IW + 24;

  // ring state
  logic [IW-1:0]           head_r;
  logic [CW-1:0]           used_r;
  logic [31:0]             nseq_r;
  logic [REGION_COUNT-1:0] valid_r;

  // per-item working registers
  logic [1:0]    op_r;
  logic [16:0]   rs_r;
  logic [7:0]    dsum_r;
  logic [27:0]   off_r;
  logic [CW-1:0] n_r;
  logic [CW-1:0] k_r;
  logic          grown_r;
  logic [30:0]   total_r;
  logic [30:0]   freed_r;
  logic [1:0]    stat_r;
  logic          addr_en_r;
  logic [IW-1:0] idx_r;
  logic          fvalid_r;
  logic [PW-1:0] prod_r;
  logic          out_valid_r;

  logic [23:0]   ram_rdata;
  logic          ram_we;
  logic [23:0]   ram_wdata;

  // ring position k -> physical region
  logic [SW-1:0] ring_sum;
  logic [SW-1:0] ring_wrap;
  logic [IW-1:0] ring_idx;
  assign ring_sum  = SW'(head_r) + SW'(k_r);
  assign ring_wrap = (ring_sum >= SW'(REGION_COUNT)) ? ring_sum - SW'(REGION_COUNT) : ring_sum;
  assign ring_idx  = ring_wrap[IW-1:0];

  // fill of the region just read; unwritten entries read as header only
  logic [23:0] fill_q;
  logic [23:0] free_q;
  assign fill_q = fvalid_r ? ram_rdata : crlm_pkg::REGION_HDR;
  assign free_q = (fill_q >= region_size) ? 24'd0 : region_size - fill_q;

  // locate walk arithmetic
  logic [27:0] off8;
  logic [27:0] rem;
  logic [28:0] off_end;
  assign off8    = off_r + 28'd8;
  assign rem     = off8 - 28'(fill_q);
  assign off_end = 29'(off8) + 29'(crlm_pkg::RECORD_HDR);

  logic [30:0] total_sum;
  assign total_sum = total_r + 31'(free_q);

  // clear count: zero or above ring size means all
  logic [CW-1:0] n_in;
  assign n_in = (in_clear_count == 7'd0 || in_clear_count > 7'(REGION_COUNT)) ?
                CW'(REGION_COUNT) : CW'(in_clear_count);

  // head advance and used count after a clear
  logic [SW-1:0] head_sum;
  logic [SW-1:0] head_wrap;
  assign head_sum  = SW'(head_r) + SW'(n_r);
  assign head_wrap = (head_sum >= SW'(REGION_COUNT)) ? head_sum - SW'(REGION_COUNT) : head_sum;

  // status to controller
  always_comb begin
    st.op        = op_r;
    st.fits      = (24'(rs_r) <= free_q);
    st.can_grow  = !grown_r && (used_r < CW'(REGION_COUNT));
    st.loc_hit   = (off8 < 28'(fill_q));
    st.loc_last  = (k_r + CW'(1) == used_r);
    st.free_last = (k_r == CW'(REGION_COUNT - 1));
    st.clr_last  = (k_r + CW'(1) == n_r);
    st.out_busy  = out_valid_r && !out_ready;
  end

  // fill memory write port
  assign ram_we    = (cmd == crlm_pkg::CMD_APP_OK) || (cmd == crlm_pkg::CMD_CLR_WRITE);
  assign ram_wdata = (cmd == crlm_pkg::CMD_APP_OK) ? fill_q + 24'(rs_r) : crlm_pkg::REGION_HDR;

  crlm_ram #(
    .WIDTH (24),
    .DEPTH (REGION_COUNT)
  ) u_fill_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (ring_idx),
    .rdata (ram_rdata)
  );

  // header checksum of an append
  logic [7:0] csum;
  assign csum = 8'd0 - (rs_r[7:0] + rs_r[15:8] + dsum_r);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      used_r      <= CW'(1);
      nseq_r      <= 32'(REGION_COUNT);
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd == crlm_pkg::CMD_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (ram_we) begin
        valid_r[idx_r] <= 1'b1;
      end
      case (cmd)
        crlm_pkg::CMD_APP_GROW: begin
          used_r <= used_r + CW'(1);
        end
        crlm_pkg::CMD_EMIT: begin
          if (op_r == crlm_pkg::OP_CLEAR) begin
            nseq_r <= nseq_r + 32'd1;
            if (st.clr_last) begin
              head_r <= head_wrap[IW-1:0];
              used_r <= (used_r <= n_r) ? CW'(1) : used_r - n_r;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd)
      crlm_pkg::CMD_LOAD: begin
        op_r      <= in_operation;
        rs_r      <= 17'(in_length) + crlm_pkg::RECORD_HDR;
        dsum_r    <= in_data_sum;
        off_r     <= 28'(in_log_offset);
        n_r       <= n_in;
        grown_r   <= 1'b0;
        total_r   <= '0;
        freed_r   <= '0;
        stat_r    <= crlm_pkg::ST_OK;
        addr_en_r <= 1'b0;
        k_r       <= (in_operation == crlm_pkg::OP_APPEND || in_operation == crlm_pkg::OP_FREE) ?
                     used_r - CW'(1) : '0;
      end
      crlm_pkg::CMD_READ: begin
        idx_r    <= ring_idx;
        fvalid_r <= valid_r[ring_idx];
      end
      crlm_pkg::CMD_APP_OK: begin
        off_r     <= 28'(fill_q);
        addr_en_r <= 1'b1;
      end
      crlm_pkg::CMD_APP_GROW: begin
        k_r     <= used_r;
        grown_r <= 1'b1;
      end
      crlm_pkg::CMD_APP_FAIL: begin
        stat_r <= crlm_pkg::ST_NO_SPACE;
      end
      crlm_pkg::CMD_LOC_HIT: begin
        off_r <= off8;
        if (off_end > 29'(region_size)) begin
          stat_r <= crlm_pkg::ST_INVALID;
        end else begin
          addr_en_r <= 1'b1;
        end
      end
      crlm_pkg::CMD_LOC_NEXT: begin
        off_r <= rem;
        k_r   <= k_r + CW'(1);
      end
      crlm_pkg::CMD_LOC_END: begin
        stat_r <= (rem == 28'd0 || rem == 28'(fill_q)) ? crlm_pkg::ST_END : crlm_pkg::ST_INVALID;
      end
      crlm_pkg::CMD_FREE_NEXT: begin
        total_r <= total_sum;
        k_r     <= k_r + CW'(1);
      end
      crlm_pkg::CMD_FREE_DONE: begin
        total_r <= (total_sum > 31'd3) ? total_sum - 31'd3 : '0;
      end
      crlm_pkg::CMD_CLR_WRITE: begin
        freed_r   <= freed_r + 31'(region_size);
        off_r     <= '0;
        addr_en_r <= 1'b1;
      end
      crlm_pkg::CMD_MUL: begin
        prod_r <= PW'(idx_r) * PW'(region_size);
      end
      crlm_pkg::CMD_EMIT: begin
        if (op_r == crlm_pkg::OP_CLEAR) begin
          k_r <= k_r + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd == crlm_pkg::CMD_EMIT) begin
      out_status          <= stat_r;
      out_flash_address   <= addr_en_r ? base_address + 32'(prod_r) + 32'(off_r) : 32'd0;
      out_region_index    <= (op_r == crlm_pkg::OP_FREE) ? 6'd0 : 6'(idx_r);
      out_header_checksum <= (op_r == crlm_pkg::OP_APPEND && stat_r == crlm_pkg::ST_OK) ?
                             csum : 8'd0;
      out_region_offset   <= ((op_r == crlm_pkg::OP_APPEND || op_r == crlm_pkg::OP_LOCATE) &&
                              stat_r == crlm_pkg::ST_OK) ? off_r[23:0] : 24'd0;
      out_sequence_number <= (op_r == crlm_pkg::OP_CLEAR) ? nseq_r : 32'd0;
      out_last            <= (op_r == crlm_pkg::OP_CLEAR) ? st.clr_last : 1'b1;
      case (op_r)
        crlm_pkg::OP_APPEND: out_amount <= 31'(rs_r);
        crlm_pkg::OP_FREE:   out_amount <= total_r;
        crlm_pkg::OP_CLEAR:  out_amount <= st.clr_last ? freed_r : 31'd0;
        default:             out_amount <= 31'd0;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> dv/crlm_checker.sv
// ----------------------------------------------------------------------------
// crlm_checker
// Watches the input, result and register channels of the log region manager,
// keeps its own copy of the ring state, predicts every result and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module crlm_checker #(
  parameter int REGION_COUNT = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire  [63:0]  in_tdata,
  input  wire  [1:0]   in_tuser,
  input  wire          in_tvalid,
  input  wire          in_tready,
  input  wire  [135:0] out_tdata,
  input  wire          out_tlast,
  input  wire          out_tvalid,
  input  wire          out_tready,
  input  wire          cfg_psel,
  input  wire          cfg_penable,
  input  wire          cfg_pwrite,
  input  wire  [2:0]   cfg_paddr,
  input  wire  [31:0]  cfg_pwdata,
  input  wire          cfg_pready,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] flash_address;
    logic [30:0] amount;
    logic [7:0]  header_checksum;
    logic [5:0]  region_index;
    logic [23:0] region_offset;
    logic [31:0] sequence_number;
    logic        last;
  } log_result_t;

  // Shadow ring state
  logic [31:0] base_addr;
  logic [23:0] rsize;
  logic [31:0] fill_lvl [REGION_COUNT];
  logic [31:0] seq_num  [REGION_COUNT];
  int unsigned head, used;
  logic [31:0] next_seq;

  log_result_t expected_q[$];

  assign pending = expected_q.size();

  function automatic int unsigned ring_pos(int unsigned k);
    return (head + k) % REGION_COUNT;
  endfunction

  function automatic logic [31:0] free_bytes(int unsigned r);
    return (fill_lvl[r] >= rsize) ? 32'd0 : rsize - fill_lvl[r];
  endfunction

  function automatic logic [31:0] region_start(int unsigned r);
    return base_addr + r * rsize;
  endfunction

  // Work out the results of one input transaction and update the shadow
  task automatic predict_log_op(input logic [1:0] op, input logic [63:0] d);
    logic [15:0]  len;
    logic [7:0]   dsum;
    logic [63:0]  off, total, freed;
    int unsigned  n, k, r, tail;
    logic [31:0]  rs;
    log_result_t  res;
    len = d[15:0];
    dsum = d[23:16];
    off = {37'd0, d[50:24]};
    n = d[57:51];
    res = '0;
    res.last = 1'b1;
    case (op)
      crlm_pkg::OP_APPEND: begin
        rs = 32'(len) + 32'd3;
        tail = ring_pos(used - 1);
        if (rs > free_bytes(tail) && used < REGION_COUNT) begin
          used++;
          tail = ring_pos(used - 1);
        end
        res.amount = rs[30:0];
        res.region_index = 6'(tail);
        if (rs > free_bytes(tail)) begin
          res.status = crlm_pkg::ST_NO_SPACE;
        end else begin
          res.status = crlm_pkg::ST_OK;
          res.flash_address = region_start(tail) + fill_lvl[tail];
          res.header_checksum = 8'h00 - (rs[7:0] + rs[15:8] + dsum);
          res.region_offset = fill_lvl[tail][23:0];
          fill_lvl[tail] = fill_lvl[tail] + rs;
        end
        expected_q.push_back(res);
      end
      crlm_pkg::OP_LOCATE: begin
        r = ring_pos(0);
        for (k = 0; k < used; k++) begin
          off += 8;
          r = ring_pos(k);
          if (off < fill_lvl[r]) break;
          off -= fill_lvl[r];
        end
        res.region_index = 6'(r);
        if (k >= used)
          res.status = (off == 0 || off == fill_lvl[r]) ? crlm_pkg::ST_END : crlm_pkg::ST_INVALID;
        else if (off + 3 > rsize)
          res.status = crlm_pkg::ST_INVALID;
        else begin
          res.status = crlm_pkg::ST_OK;
          res.flash_address = region_start(r) + off[31:0];
          res.region_offset = off[23:0];
        end
        expected_q.push_back(res);
      end
      crlm_pkg::OP_FREE: begin
        total = 0;
        for (k = used - 1; k < REGION_COUNT; k++) total += free_bytes(ring_pos(k));
        total = (total > 3) ? total - 3 : 64'd0;
        res.amount = total[30:0];
        expected_q.push_back(res);
      end
      default: begin
        if (n == 0 || n > REGION_COUNT) n = REGION_COUNT;
        freed = 0;
        for (k = 0; k < n; k++) begin
          r = ring_pos(k);
          freed += rsize;
          fill_lvl[r] = 8;
          seq_num[r] = next_seq;
          next_seq++;
          res = '0;
          res.flash_address = region_start(r);
          res.region_index = 6'(r);
          res.sequence_number = seq_num[r];
          res.last = (k + 1 == n);
          if (res.last) res.amount = freed[30:0];
          expected_q.push_back(res);
        end
        head = (head + n) % REGION_COUNT;
        used = (used <= n) ? 1 : used - n;
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h actual 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Monitor all channels at the rising edge
  always @(posedge clk) begin
    log_result_t got, want;
    if (!rst_n) begin
      base_addr = '0;
      rsize = crlm_pkg::REGION_SIZE_RST;
      for (int i = 0; i < REGION_COUNT; i++) begin
        fill_lvl[i] = 8;
        seq_num[i] = i;
      end
      head = 0;
      used = 1;
      next_seq = REGION_COUNT;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == crlm_pkg::REG_BASE_ADDRESS) base_addr = cfg_pwdata;
        else if (cfg_paddr == crlm_pkg::REG_REGION_SIZE) rsize = cfg_pwdata[23:0];
      end
      if (in_tvalid && in_tready) predict_log_op(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[1:0];
        got.flash_address = out_tdata[33:2];
        got.amount = out_tdata[64:34];
        got.header_checksum = out_tdata[72:65];
        got.region_index = out_tdata[78:73];
        got.region_offset = out_tdata[102:79];
        got.sequence_number = out_tdata[134:103];
        got.last = out_tlast;
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction 0x%0h", out_tdata);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          compare_field("status", want.status, got.status);
          compare_field("flash_address", want.flash_address, got.flash_address);
          compare_field("amount", want.amount, got.amount);
          compare_field("header_checksum", want.header_checksum, got.header_checksum);
          compare_field("region_index", want.region_index, got.region_index);
          compare_field("region_offset", want.region_offset, got.region_offset);
          compare_field("sequence_number", want.sequence_number, got.sequence_number);
          compare_field("last", want.last, got.last);
          compare_field("pad", 64'd0, {63'd0, out_tdata[135]});
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives append, locate, free space and clear transactions through the log
// region manager under random gaps and stalls, across several register
// settings; the checker module predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [63:0]  in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         in_tvalid = 1'b0;
  wire          in_tready;
  wire  [135:0] out_tdata;
  wire          out_tlast, out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  wire  [31:0]  cfg_prdata;
  wire          cfg_pready;
  int           fail_count, pending;
  int           burst_left = 0;
  bit           stall_on = 1'b0;

  always #2 clk = ~clk;

  circular_region_log_manager_unit u_top (.*);

  crlm_checker u_checker (.*);

  // Receiver stall pattern: long free-running stretches, then choppy phases
  initial begin
    int unsigned phase;
    forever begin
      phase = $urandom_range(0, 3);
      repeat ($urandom_range(20, 120)) begin
        @(negedge clk);
        out_tready <= !stall_on || (phase == 0) ? 1'b1 : ($urandom_range(0, phase) == 0);
      end
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= addr; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // Send one transaction; gaps come between random-length bursts
  task automatic send_item(input logic [1:0] op, input logic [15:0] len,
                           input logic [7:0] dsum, input logic [26:0] loff,
                           input logic [6:0] ccnt);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tuser <= op;
    in_tdata <= {6'd0, ccnt, loff, dsum, len};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic random_item(input int unsigned rsz);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50)
      send_item(crlm_pkg::OP_APPEND,
                (sel < 40) ? 16'($urandom_range(0, rsz / 3)) : 16'($urandom_range(0, 65535)),
                8'($urandom), 27'd0, 7'd0);
    else if (sel < 75)
      send_item(crlm_pkg::OP_LOCATE, 16'd0, 8'd0,
                (sel < 68) ? 27'($urandom_range(0, rsz * 3)) : 27'($urandom), 7'd0);
    else if (sel < 87)
      send_item(crlm_pkg::OP_FREE, 16'($urandom), 8'($urandom), 27'($urandom), 7'($urandom));
    else
      send_item(crlm_pkg::OP_CLEAR, 16'd0, 8'd0, 27'd0,
                (sel < 97) ? 7'($urandom_range(1, 4)) : 7'($urandom_range(0, 127)));
  endtask

  // Stimulus
  initial begin
    logic [31:0] bases[4] = '{32'h0, 32'hFFFF_F000, 32'h1234_5678, 32'hFFFF_FFFF};
    logic [23:0] sizes[4] = '{24'd4096, 24'd16, 24'd200, 24'hFF_FFFF};
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    // Directed: default sizes, field extremes, every operation
    send_item(crlm_pkg::OP_FREE, 16'd0, 8'd0, 27'd0, 7'd0);
    send_item(crlm_pkg::OP_LOCATE, 16'd0, 8'd0, 27'd0, 7'd0);
    send_item(crlm_pkg::OP_APPEND, 16'd0, 8'hFF, 27'd0, 7'd0);
    send_item(crlm_pkg::OP_APPEND, 16'd4000, 8'h00, 27'd0, 7'd0);
    send_item(crlm_pkg::OP_APPEND, 16'd65535, 8'hA5, 27'd0, 7'd0);
    send_item(crlm_pkg::OP_LOCATE, 16'd0, 8'd0, 27'd3, 7'd0);
    send_item(crlm_pkg::OP_LOCATE, 16'd0, 8'd0, 27'd4003, 7'd0);
    send_item(crlm_pkg::OP_LOCATE, 16'd0, 8'd0, 27'h7FF_FFFF, 7'd0);
    send_item(crlm_pkg::OP_FREE, 16'hFFFF, 8'hFF, 27'h7FF_FFFF, 7'h7F);
    send_item(crlm_pkg::OP_CLEAR, 16'd0, 8'd0, 27'd0, 7'd1);
    send_item(crlm_pkg::OP_CLEAR, 16'd0, 8'd0, 27'd0, 7'd0);
    send_item(crlm_pkg::OP_CLEAR, 16'd0, 8'd0, 27'd0, 7'd127);
    repeat (8) send_item(crlm_pkg::OP_APPEND, 16'd4085, 8'h5A, 27'd0, 7'd0);
    send_item(crlm_pkg::OP_FREE, 16'd0, 8'd0, 27'd0, 7'd0);
    send_item(crlm_pkg::OP_LOCATE, 16'd0, 8'd0, 27'd32000, 7'd0);
    send_item(crlm_pkg::OP_CLEAR, 16'd0, 8'd0, 27'd0, 7'd9);
    drain();
    // Random phases across register settings
    for (int p = 0; p < 6; p++) begin
      reg_write(crlm_pkg::REG_BASE_ADDRESS, (p < 4) ? bases[p] : $urandom);
      reg_write(crlm_pkg::REG_REGION_SIZE,
                (p < 4) ? {8'd0, sizes[p]} : $urandom_range(16, 5000));
      stall_on = (p % 2 == 1);
      repeat (52) random_item((p < 4) ? ((sizes[p] > 20000) ? 20000 : sizes[p]) : 3000);
      drain();
    end
    if (fail_count == 0) begin
      $display("PASS circular_region_log_manager_unit");
    end else begin
      $display("FAIL circular_region_log_manager_unit");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2ms;
    $display("FAIL circular_region_log_manager_unit");
    $finish;
  end

endmodule

`default_nettype wire
